### rtl/overwriting_record_ring_log_unit_defines.svh
// Assertion macros shared by the ring log RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef OVERWRITING_RECORD_RING_LOG_UNIT_DEFINES_SVH
`define OVERWRITING_RECORD_RING_LOG_UNIT_DEFINES_SVH

// cond must hold at every edge out of reset
`define ORRL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// pre at one edge implies post at the next
`define ORRL_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/orrl_pkg.sv
// Types and codes for the overwriting record ring log.
// No dependencies; used by the top level, the front end and the back end.
package orrl_pkg;

    localparam logic [1:0] OP_STORE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_RESTORE = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    localparam int ID_W = 16;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] record_payload;
        logic [15:0] meta_write_index;
        logic [15:0] meta_record_count;
        logic [31:0] meta_magic;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] entry_id;
        logic [47:0] record_out;
        logic        last_item;
        logic [6:0]  stored_count;
        logic [5:0]  next_slot;
        logic        ring_full;
    } out_item_t;

    // decoded request handed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic [47:0] payload;
        logic [5:0]  meta_slot;
        logic [6:0]  meta_count;
        logic        meta_ok;
    } cmd_t;

endpackage

### rtl/overwriting_record_ring_log_unit.sv
// Overwriting record ring log, top level.
// Instantiates orrl_front, orrl_back and two orrl_fifo queues; uses orrl_pkg.
//
// Requests come in on a queue-style port: a beat is taken when push is high
// and full is low. Results leave on a queue-style port: the oldest result sits
// on result while empty is low and goes when pop is high. The magic word is
// written through cfg_valid/cfg_data; cfg_ready is always high.
// A store, clear or restore gives one result; its beat is on result once the
// back end has taken the request from the command queue and written the result
// queue, and it can be popped from then on.
// A read-all gives one beat per held record, oldest first, or one empty beat;
// the first record comes later than a single result because of
// the registered memory read, then one record per cycle while the result queue has room.
// Single-result requests sustain one per cycle while the result queue has room;
// a read-all holds the back end until its last record goes out. The back end's
// sequencer and the memory read port set this behaviour.
// Reset clears the indices, count, wrap flag, id counter and magic word; the
// record memory is not cleared. When the receiver stalls, the result queue
// fills, the back end holds, then the command queue fills and full rises.
module overwriting_record_ring_log_unit #(
    parameter int RECORD_SLOTS = 64,
    parameter int PAYLOAD_BITS = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  orrl_pkg::in_item_t  request,
    output logic                empty,
    input  logic                pop,
    output orrl_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);

    localparam int CMD_W     = $bits(orrl_pkg::cmd_t);
    localparam int RES_W     = $bits(orrl_pkg::out_item_t);
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    orrl_pkg::cmd_t      front_cmd, back_cmd;
    orrl_pkg::out_item_t back_res;
    logic                cmd_push, cmd_full, cmd_empty, cmd_pop;
    logic                res_push, res_full;
    logic [CMD_W-1:0]    cmd_rd_data;
    logic [RES_W-1:0]    res_rd_data;

    orrl_front #(
        .RECORD_SLOTS (RECORD_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (front_cmd),
        .cmd_push  (cmd_push),
        .cmd_full  (cmd_full)
    );

    orrl_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_rd_data),
        .empty   (cmd_empty)
    );

    assign back_cmd = orrl_pkg::cmd_t'(cmd_rd_data);

    orrl_back #(
        .RECORD_SLOTS (RECORD_SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (!cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (back_res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    orrl_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign result = orrl_pkg::out_item_t'(res_rd_data);

endmodule

### rtl/orrl_fifo.sv
// Small register queue used between front and back and on the result side.
// Depends on the defines header for its assertions.
`include "overwriting_record_ring_log_unit_defines.svh"

module orrl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_MAX);
    assign empty   = (count_reg == '0);
    assign do_wr   = push && !full;
    assign do_rd   = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ORRL_ASSERT_ALWAYS(a_fifo_bound, count_reg <= CNT_MAX, "fifo count above depth")
    `ORRL_ASSERT_NEXT(a_fifo_fill, do_wr && !do_rd, !empty, "fifo empty after a lone push")

endmodule

### rtl/orrl_front.sv
// Front end: takes request beats, holds the magic register, decodes and
// checks restore metadata. Depends on orrl_pkg.
module orrl_front #(
    parameter int RECORD_SLOTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  orrl_pkg::in_item_t  request,
    output logic                full,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data,
    output orrl_pkg::cmd_t      cmd,
    output logic                cmd_push,
    input  logic                cmd_full
);

    logic [31:0] magic_reg;

    assign cfg_ready = 1'b1;
    assign full      = cmd_full;
    assign cmd_push  = push && !cmd_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            magic_reg <= cfg_data;
        end
    end

    always_comb
    begin
        cmd.op         = request.req_type;
        cmd.payload    = request.record_payload;
        cmd.meta_slot  = request.meta_write_index[5:0];
        cmd.meta_count = request.meta_record_count[6:0];
        cmd.meta_ok    = (request.meta_magic == magic_reg)
                      && (request.meta_write_index < 16'(RECORD_SLOTS))
                      && (request.meta_record_count <= 16'(RECORD_SLOTS));
    end

endmodule

### rtl/orrl_back.sv
// Back end: ring state, record memory and the read-all sequencer.
// Depends on orrl_pkg and the defines header.
`include "overwriting_record_ring_log_unit_defines.svh"

module orrl_back #(
    parameter int RECORD_SLOTS = 64,
    parameter int PAYLOAD_BITS = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  orrl_pkg::cmd_t      cmd,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    output orrl_pkg::out_item_t res,
    output logic                res_push,
    input  logic                res_full
);

    localparam int SLOT_W = $clog2(RECORD_SLOTS);
    localparam int CNT_W  = $clog2(RECORD_SLOTS + 1);
    localparam int EXT_W  = CNT_W + 1;
    localparam int REC_W  = orrl_pkg::ID_W + PAYLOAD_BITS;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RECORD_SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(RECORD_SLOTS);
    localparam logic [EXT_W-1:0]  EXT_SLOTS = EXT_W'(RECORD_SLOTS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic [REC_W-1:0]  mem [RECORD_SLOTS];
    logic [REC_W-1:0]  rd_data_reg;

    logic              state_reg, state_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              wrapped_reg, wrapped_next;
    logic [15:0]       id_reg, id_next;
    logic [SLOT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  rd_left_reg, rd_left_next;

    logic              go;
    logic              store_go;
    logic              mem_wr, mem_rd;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wslot_inc, rd_ptr_inc, start_slot;
    logic [EXT_W-1:0]  start_sum;

    assign go         = cmd_valid && !res_full;
    assign store_go   = (state_reg == ST_IDLE) && go && (cmd.op == orrl_pkg::OP_STORE);
    assign wslot_inc  = (wslot_reg == SLOT_LAST) ? '0 : wslot_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == SLOT_LAST) ? '0 : rd_ptr_reg + 1'b1;
    // oldest record: (write slot - count) mod slots
    assign start_sum  = EXT_W'(wslot_reg) + EXT_SLOTS - EXT_W'(count_reg);
    assign start_slot = (start_sum >= EXT_SLOTS) ? SLOT_W'(start_sum - EXT_SLOTS)
                                                 : SLOT_W'(start_sum);

    always_comb
    begin
        state_next   = state_reg;
        wslot_next   = wslot_reg;
        count_next   = count_reg;
        wrapped_next = wrapped_reg;
        id_next      = id_reg;
        rd_ptr_next  = rd_ptr_reg;
        rd_left_next = rd_left_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        mem_wr       = 1'b0;
        mem_rd       = 1'b0;
        rd_addr      = rd_ptr_inc;
        res.status     = orrl_pkg::STATUS_OK;
        res.entry_id   = '0;
        res.record_out = '0;
        res.last_item  = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        orrl_pkg::OP_STORE:
                        begin
                            mem_wr       = 1'b1;
                            res_push     = 1'b1;
                            res.entry_id = id_reg;
                            id_next      = id_reg + 16'd1;
                            wslot_next   = wslot_inc;
                            if (count_reg < CNT_FULL)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                wrapped_next = 1'b1;
                            end
                        end
                        orrl_pkg::OP_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_push   = 1'b1;
                                res.status = orrl_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_rd       = 1'b1;
                                rd_addr      = start_slot;
                                rd_ptr_next  = start_slot;
                                rd_left_next = count_reg;
                                state_next   = ST_READ;
                            end
                        end
                        orrl_pkg::OP_CLEAR:
                        begin
                            res_push     = 1'b1;
                            wslot_next   = '0;
                            count_next   = '0;
                            wrapped_next = 1'b0;
                            id_next      = '0;
                        end
                        orrl_pkg::OP_RESTORE:
                        begin
                            res_push = 1'b1;
                            if (cmd.meta_ok)
                            begin
                                wslot_next   = cmd.meta_slot[SLOT_W-1:0];
                                count_next   = cmd.meta_count[CNT_W-1:0];
                                wrapped_next = (cmd.meta_count[CNT_W-1:0] == CNT_FULL);
                                id_next      = 16'(cmd.meta_count);
                            end
                            else
                            begin
                                res.status   = orrl_pkg::STATUS_BAD;
                                wslot_next   = '0;
                                count_next   = '0;
                                wrapped_next = 1'b0;
                                id_next      = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // rd_data_reg holds the record at rd_ptr_reg until its beat goes out
                res.entry_id   = rd_data_reg[REC_W-1 -: orrl_pkg::ID_W];
                res.record_out = 48'(rd_data_reg[PAYLOAD_BITS-1:0]);
                res.last_item  = (rd_left_reg == CNT_W'(1));
                if (!res_full)
                begin
                    res_push     = 1'b1;
                    rd_left_next = rd_left_reg - 1'b1;
                    if (rd_left_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_rd      = 1'b1;
                        rd_ptr_next = rd_ptr_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res.stored_count = 7'(count_next);
        res.next_slot    = 6'(wslot_next);
        res.ring_full    = wrapped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wslot_reg   <= '0;
            count_reg   <= '0;
            wrapped_reg <= 1'b0;
            id_reg      <= '0;
            rd_ptr_reg  <= '0;
            rd_left_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            wslot_reg   <= wslot_next;
            count_reg   <= count_next;
            wrapped_reg <= wrapped_next;
            id_reg      <= id_next;
            rd_ptr_reg  <= rd_ptr_next;
            rd_left_reg <= rd_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[wslot_reg] <= {id_reg, cmd.payload[PAYLOAD_BITS-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `ORRL_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_FULL, "record count above capacity")
    `ORRL_ASSERT_ALWAYS(a_wrap_full, !wrapped_reg || count_reg == CNT_FULL, "wrapped, not full")
    `ORRL_ASSERT_ALWAYS(a_read_left, state_reg != ST_READ || rd_left_reg != '0, "read run empty")
    `ORRL_ASSERT_NEXT(a_store_id, store_go, id_reg == $past(id_reg) + 16'd1, "id not advanced")

endmodule
